>>> sv/particulate_sensor_frame_parser_assert.svh
// assertion macros shared by the checkers of the frame parser
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef PARTICULATE_SENSOR_FRAME_PARSER_ASSERT_SVH
`define PARTICULATE_SENSOR_FRAME_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PSFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame parser port check failed");

// consequent must hold in the cycle after the antecedent
`define PSFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame parser port check failed");

`endif

>>> sv/psfp_pkg.sv
// shared constants, types and channel table of the frame parser
// used by psfp_ctrl, psfp_dpath and the top level; depends on nothing
package psfp_pkg;

  localparam int MaxFrameBytes = 40;
  localparam int AddrW = $clog2(MaxFrameBytes);
  localparam int TotW = $clog2(MaxFrameBytes + 1);
  localparam int CmpW = TotW + 1;
  localparam int NumChan = 15;
  localparam int ChanW = 4;

  localparam logic [7:0] StartOne = 8'h42;
  localparam logic [7:0] StartTwo = 8'h4D;

  localparam logic [15:0] LenFull = 16'd28;
  localparam logic [15:0] LenShort = 16'd20;
  localparam logic [15:0] LenExt = 16'd36;

  localparam logic [TotW-1:0] OffFirst = TotW'(4);
  localparam logic [TotW-1:0] OffHcho = TotW'(28);
  localparam logic [TotW-1:0] OffTrhShort = TotW'(24);
  localparam logic [TotW-1:0] OffTrhLong = TotW'(30);

  typedef enum logic [1:0] {
    TypeBasic   = 2'd0,
    TypeTrh     = 2'd1,
    TypeHcho    = 2'd2,
    TypeHchoTrh = 2'd3
  } sensor_type_e;

  typedef enum logic [0:0] {
    CfgSensorType = 1'b0,
    CfgChanEnable = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ErrStart    = 2'd0,
    ErrLength   = 2'd1,
    ErrChecksum = 2'd2
  } err_code_e;

  typedef enum logic [1:0] {
    OutcomeNone  = 2'd0,
    OutcomeError = 2'd1,
    OutcomeFrame = 2'd2
  } outcome_e;

  typedef struct packed {
    logic load_byte;
    logic commit;
    logic rd_hi;
    logic rd_lo;
    logic emit;
  } psfp_cmd_t;

  typedef struct packed {
    outcome_e outcome;
    logic     frame_nonempty;
    logic     out_free;
    logic     last_chan;
  } psfp_status_t;

  // does the sensor type report this channel at all
  function automatic logic chan_present(logic [ChanW-1:0] c, sensor_type_e t);
    logic p;
    case (c) inside
      [4'd0:4'd9]:   p = 1'b1;
      4'd10, 4'd11:  p = (t != TypeTrh);
      4'd12:         p = (t == TypeHcho) || (t == TypeHchoTrh);
      4'd13, 4'd14:  p = (t == TypeTrh) || (t == TypeHchoTrh);
      default:       p = 1'b0;
    endcase
    return p;
  endfunction

  // byte offset of the high byte of a channel's word in the frame
  function automatic logic [TotW-1:0] chan_offset(logic [ChanW-1:0] c, sensor_type_e t);
    logic [TotW-1:0] trh;
    logic [TotW-1:0] off;
    trh = (t == TypeTrh) ? OffTrhShort : OffTrhLong;
    case (c) inside
      [4'd0:4'd11]: off = OffFirst + (TotW'(c) << 1);
      4'd12:        off = OffHcho;
      4'd13:        off = trh;
      4'd14:        off = trh + TotW'(2);
      default:      off = OffFirst;
    endcase
    return off;
  endfunction

endpackage

>>> sv/particulate_sensor_frame_parser.sv
// top level of the particulate sensor frame parser
// depends on psfp_pkg, psfp_ctrl, psfp_dpath (and psfp_ram through it)
//
// usage:
// - s_axis carries one received serial byte per transfer in tdata[7:0]
// - m_axis carries results: tuser is the kind (0 measurement, 1 rejected
//   frame), tlast marks the final result caused by one byte
// - cfg writes sensor_type (index 0) or channel_enable (index 1); always
//   ready, write only while no frame is being drained
// - timing: a byte is taken into a register and checked in the next cycle, so no new
//   byte is taken until the last one is checked; the frame-store read port
//   sets the drain, two byte reads and one output write per measurement
//   result, up to 15 results after the final checksum byte
// - a rejected frame gives its single error result in the check cycle
// - reset clears the position, sum and length, loads sensor type 0 and
//   all channels enabled; the frame store holds no reset value
// - when the receiver stalls, the held result stays in the output register;
//   the next byte is still taken, and a check that rejects the frame, or the
//   drain, waits for the output register to free up
module particulate_sensor_frame_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,   // [3:0] channel, [19:4] value,
                                                       // [21:20] reject reason, rest zero
  output logic [0:0]                   m_axis_tuser,   // [0] kind
  output logic                         m_axis_tlast,   // last
  // register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [psfp_pkg::NumChan-1:0] cfg_data_i
);

  psfp_pkg::psfp_cmd_t    cmd;
  psfp_pkg::psfp_status_t status;

  logic                        out_kind;
  logic [psfp_pkg::ChanW-1:0]  out_chan;
  logic [15:0]                 out_value;
  logic [1:0]                  out_err;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  psfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  psfp_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o (out_kind),
    .out_chan_o (out_chan),
    .out_value_o(out_value),
    .out_err_o  (out_err),
    .out_last_o (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {2'b00, out_err, out_value, out_chan};
  assign m_axis_tuser = out_kind;

endmodule

>>> sv/psfp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module psfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/psfp_ctrl.sv
// controller of the frame parser: byte intake, per-byte commit and result drain
// depends on psfp_pkg
module psfp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  psfp_pkg::psfp_status_t  status_i,
  output psfp_pkg::psfp_cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StProc = 5'b00010,
    StRdHi = 5'b00100,
    StRdLo = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d = StProc;
        end
      end
      StProc: begin
        case (status_i.outcome)
          psfp_pkg::OutcomeError: begin
            // error result needs the output slot
            if (status_i.out_free) begin
              cmd_o.commit = 1'b1;
              state_d = StIdle;
            end
          end
          psfp_pkg::OutcomeFrame: begin
            cmd_o.commit = 1'b1;
            state_d = status_i.frame_nonempty ? StRdHi : StIdle;
          end
          psfp_pkg::OutcomeNone: begin
            cmd_o.commit = 1'b1;
            state_d = StIdle;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StRdHi: begin
        cmd_o.rd_hi = 1'b1;
        state_d = StRdLo;
      end
      StRdLo: begin
        cmd_o.rd_lo = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = status_i.last_chan ? StIdle : StRdHi;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/psfp_dpath.sv
// datapath of the frame parser: config registers, frame checks, frame store,
// channel mask and output register; depends on psfp_pkg and psfp_ram
module psfp_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [0:0]                           cfg_index_i,
  input  logic [psfp_pkg::NumChan-1:0]         cfg_data_i,
  input  logic [7:0]                           in_data_i,
  input  psfp_pkg::psfp_cmd_t                  cmd_i,
  output psfp_pkg::psfp_status_t               status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 out_kind_o,
  output logic [psfp_pkg::ChanW-1:0]           out_chan_o,
  output logic [15:0]                          out_value_o,
  output logic [1:0]                           out_err_o,
  output logic                                 out_last_o
);

  psfp_pkg::sensor_type_e sensor_type_q;
  logic [psfp_pkg::NumChan-1:0] chan_en_q;

  logic [7:0]                  byte_q;
  logic [7:0]                  prev_q;
  logic [7:0]                  hi_q;
  logic [psfp_pkg::AddrW-1:0]  pos_q, pos_d;
  logic [15:0]                 sum_q, sum_d;
  logic [psfp_pkg::TotW-1:0]   total_q, total_d;
  logic [psfp_pkg::NumChan-1:0] mask_q;

  logic                        out_valid_q;
  logic                        out_kind_q;
  logic [psfp_pkg::ChanW-1:0]  out_chan_q;
  logic [15:0]                 out_value_q;
  logic [1:0]                  out_err_q;
  logic                        out_last_q;

  // per-byte evaluation
  logic [psfp_pkg::AddrW-1:0]  pos_eff;
  logic [psfp_pkg::CmpW-1:0]   pos_ext;
  logic [psfp_pkg::CmpW-1:0]   tot_ext;
  logic [15:0]                 len;
  logic                        len_ok;
  logic [psfp_pkg::TotW-1:0]   len_total;
  psfp_pkg::outcome_e          outcome;
  psfp_pkg::err_code_e         err_code;
  logic [psfp_pkg::NumChan-1:0] frame_mask;

  // drain
  logic [psfp_pkg::NumChan-1:0] lowest;
  logic [psfp_pkg::ChanW-1:0]   cur_chan;
  logic [psfp_pkg::TotW-1:0]    cur_off;
  logic [psfp_pkg::AddrW-1:0]   rd_addr;
  logic [7:0]                   ram_rdata;
  logic                         out_free;
  logic                         out_wr;

  assign pos_eff = (psfp_pkg::TotW'(pos_q) >= psfp_pkg::TotW'(psfp_pkg::MaxFrameBytes))
                   ? '0 : pos_q;
  assign pos_ext = psfp_pkg::CmpW'(pos_eff);
  assign len = {prev_q, byte_q};
  assign len_total = psfp_pkg::TotW'(len) + psfp_pkg::TotW'(4);

  always_comb begin
    case (sensor_type_q)
      psfp_pkg::TypeBasic:   len_ok = (len == psfp_pkg::LenFull) ||
                                      (len == psfp_pkg::LenShort);
      psfp_pkg::TypeTrh,
      psfp_pkg::TypeHcho:    len_ok = (len == psfp_pkg::LenFull);
      psfp_pkg::TypeHchoTrh: len_ok = (len == psfp_pkg::LenExt);
      default:               len_ok = 1'b0;
    endcase
    if ((17'(len) + 17'd4) > 17'(psfp_pkg::MaxFrameBytes)) begin
      len_ok = 1'b0;
    end
  end

  // frame length takes effect at the fourth byte
  assign tot_ext = (pos_eff == psfp_pkg::AddrW'(3)) ? psfp_pkg::CmpW'(len_total)
                                                     : psfp_pkg::CmpW'(total_q);

  always_comb begin
    outcome = psfp_pkg::OutcomeNone;
    err_code = psfp_pkg::ErrStart;
    pos_d = '0;
    sum_d = '0;
    total_d = '0;
    if ((pos_eff == psfp_pkg::AddrW'(0) && byte_q != psfp_pkg::StartOne) ||
        (pos_eff == psfp_pkg::AddrW'(1) && byte_q != psfp_pkg::StartTwo)) begin
      outcome = psfp_pkg::OutcomeError;
      err_code = psfp_pkg::ErrStart;
    end else if (pos_eff == psfp_pkg::AddrW'(3) && !len_ok) begin
      outcome = psfp_pkg::OutcomeError;
      err_code = psfp_pkg::ErrLength;
    end else if (pos_eff < psfp_pkg::AddrW'(4) ||
                 pos_ext + psfp_pkg::CmpW'(2) < tot_ext) begin
      // header and data bytes go into the running sum
      pos_d = pos_eff + psfp_pkg::AddrW'(1);
      sum_d = sum_q + {8'h00, byte_q};
      total_d = psfp_pkg::TotW'(tot_ext);
    end else if (pos_ext + psfp_pkg::CmpW'(1) < tot_ext) begin
      // high checksum byte, kept in prev_q
      pos_d = pos_eff + psfp_pkg::AddrW'(1);
      sum_d = sum_q;
      total_d = total_q;
    end else if ({prev_q, byte_q} != sum_q) begin
      outcome = psfp_pkg::OutcomeError;
      err_code = psfp_pkg::ErrChecksum;
    end else begin
      outcome = psfp_pkg::OutcomeFrame;
    end
  end

  // channels given for the finished frame: present, enabled, before the checksum
  always_comb begin
    for (int c = 0; c < psfp_pkg::NumChan; c++) begin
      frame_mask[c] =
        psfp_pkg::chan_present(psfp_pkg::ChanW'(c), sensor_type_q) && chan_en_q[c] &&
        (psfp_pkg::CmpW'(psfp_pkg::chan_offset(psfp_pkg::ChanW'(c), sensor_type_q))
         + psfp_pkg::CmpW'(3) < psfp_pkg::CmpW'(total_q));
    end
  end

  assign lowest = mask_q & (~mask_q + psfp_pkg::NumChan'(1));

  always_comb begin
    cur_chan = '0;
    for (int i = 0; i < psfp_pkg::NumChan; i++) begin
      if (lowest[i]) begin
        cur_chan = psfp_pkg::ChanW'(i);
      end
    end
  end

  assign cur_off = psfp_pkg::chan_offset(cur_chan, sensor_type_q);
  assign rd_addr = cmd_i.rd_lo ? psfp_pkg::AddrW'(cur_off + psfp_pkg::TotW'(1))
                               : psfp_pkg::AddrW'(cur_off);

  psfp_ram #(
    .Width(8),
    .Depth(psfp_pkg::MaxFrameBytes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(pos_eff),
    .wdata_i(byte_q),
    .re_i   (cmd_i.rd_hi | cmd_i.rd_lo),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign out_wr = (cmd_i.commit && outcome == psfp_pkg::OutcomeError) || cmd_i.emit;

  assign status_o.outcome = outcome;
  assign status_o.frame_nonempty = |frame_mask;
  assign status_o.out_free = out_free;
  assign status_o.last_chan = ((mask_q & ~lowest) == '0);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_type_q <= psfp_pkg::TypeBasic;
      chan_en_q <= '1;
      pos_q <= '0;
      sum_q <= '0;
      total_q <= '0;
      mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == psfp_pkg::CfgSensorType) begin
          sensor_type_q <= psfp_pkg::sensor_type_e'(cfg_data_i[1:0]);
        end else begin
          chan_en_q <= cfg_data_i;
        end
      end
      if (cmd_i.commit) begin
        pos_q <= pos_d;
        sum_q <= sum_d;
        total_q <= total_d;
        if (outcome == psfp_pkg::OutcomeFrame) begin
          mask_q <= frame_mask;
        end
      end else if (cmd_i.emit) begin
        mask_q <= mask_q & ~lowest;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      prev_q <= byte_q;
    end
    if (cmd_i.rd_lo) begin
      hi_q <= ram_rdata;
    end
    if (out_wr) begin
      if (cmd_i.emit) begin
        out_kind_q <= 1'b0;
        out_chan_q <= cur_chan;
        out_value_q <= {hi_q, ram_rdata};
        out_err_q <= 2'b00;
        out_last_q <= status_o.last_chan;
      end else begin
        out_kind_q <= 1'b1;
        out_chan_q <= '0;
        out_value_q <= '0;
        out_err_q <= err_code;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o = out_kind_q;
  assign out_chan_o = out_chan_q;
  assign out_value_o = out_value_q;
  assign out_err_o = out_err_q;
  assign out_last_o = out_last_q;

endmodule

>>> sv/psfp_port_chk.sv
// port-level checker for the frame parser, bound to the top level
// depends on particulate_sensor_frame_parser_assert.svh
`include "particulate_sensor_frame_parser_assert.svh"

module psfp_port_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a rejected frame is always a single, final result with empty payload
  `PSFP_ASSERT_SAME(a_err_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[19:0] == 20'd0))
  // a measurement carries no error code and a real channel
  `PSFP_ASSERT_SAME(a_meas_fields, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata[21:20] == 2'd0) && (m_axis_tdata[3:0] != 4'hF))
  // one byte is checked before the next is taken
  `PSFP_ASSERT_NEXT(a_one_byte, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a stalled result holds
  `PSFP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind particulate_sensor_frame_parser psfp_port_chk u_port_chk (.*);

>>> tb/sv/particulate_sensor_frame_parser_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for particulate_sensor_frame_parser: serial bytes in,
// measurement and reject results out, checked against a parser model kept here
// depends on psfp_pkg and the frame parser rtl
module particulate_sensor_frame_parser_tb;

  localparam int CycleLimit    = 200000;  // far above the slowest legal run
  localparam int SettleCycles  = 64;      // longer than a full 15-result drain
  localparam int IdlePct       = 35;      // idle chance per cycle on either side
  localparam int RandomBytes   = 120;
  localparam int MinPhases     = 4;       // one phase per sensor type at least
  localparam int ShowLimit     = 10;

  typedef enum logic {
    KindMeas   = 1'b0,
    KindReject = 1'b1
  } result_kind_e;

  // measurements carry a zero error code
  localparam logic [1:0] NoErr = 2'd0;

  typedef struct packed {
    result_kind_e kind;
    logic [3:0]   channel;
    logic [15:0]  value;
    logic [1:0]   err;
    logic         last;
  } parse_result_t;

  typedef enum int {
    RowByte,
    RowCfg
  } row_op_e;

  // one row of the directed table: a byte transfer or a register write
  typedef struct {
    row_op_e                       op;
    logic [7:0]                    rx;
    psfp_pkg::cfg_reg_e            idx;
    logic [psfp_pkg::NumChan-1:0]  data;
    bit                            typed;  // expectation typed in below, not predicted
    parse_result_t                 want;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [23:0]                   m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          m_axis_tlast;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [0:0]                    cfg_index_i;
  logic [psfp_pkg::NumChan-1:0]  cfg_data_i;

  particulate_sensor_frame_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // parser model state
  logic [7:0]                    store_bytes [psfp_pkg::MaxFrameBytes];
  int                            pos_q;
  int                            total_q;
  logic [15:0]                   sum_q;
  psfp_pkg::sensor_type_e        type_q;
  logic [psfp_pkg::NumChan-1:0]  enable_q;

  parse_result_t       byte_results[$];     // results of the byte just parsed
  parse_result_t       awaited_results[$];  // results still due from the block
  stim_row_t           stim_table[$];

  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  bytes_sent = 0;
  bit                  no_gaps;

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic parse_result_t reject_of(logic [1:0] code);
    return '{kind: KindReject, channel: 4'd0, value: 16'd0, err: code, last: 1'b1};
  endfunction

  function automatic void restart_frame();
    pos_q   = 0;
    sum_q   = '0;
    total_q = 0;
  endfunction

  function automatic void reset_model();
    foreach (store_bytes[i]) store_bytes[i] = '0;
    restart_frame();
    type_q   = psfp_pkg::TypeBasic;
    enable_q = '1;
  endfunction

  function automatic void apply_reg(psfp_pkg::cfg_reg_e idx,
                                    logic [psfp_pkg::NumChan-1:0] d);
    if (idx == psfp_pkg::CfgSensorType) begin
      type_q = psfp_pkg::sensor_type_e'(d[1:0]);
    end else begin
      enable_q = d;
    end
  endfunction

  // payload lengths each sensor type may announce, bounded by the store
  function automatic bit length_ok(psfp_pkg::sensor_type_e t, logic [15:0] len);
    bit ok;
    case (t)
      psfp_pkg::TypeBasic: ok = (len == psfp_pkg::LenFull) ||
                                (len == psfp_pkg::LenShort);
      psfp_pkg::TypeTrh,
      psfp_pkg::TypeHcho:  ok = (len == psfp_pkg::LenFull);
      default:             ok = (len == psfp_pkg::LenExt);
    endcase
    return ok && (int'(len) + 4 <= psfp_pkg::MaxFrameBytes);
  endfunction

  // good frame: one word per enabled channel that the type carries, in order
  function automatic void drain_frame();
    int c;
    int off;
    bit have;
    for (c = 0; c < psfp_pkg::NumChan; c++) begin
      if (c < 10) begin
        have = 1'b1;
      end else if (c < 12) begin
        have = (type_q != psfp_pkg::TypeTrh);
      end else if (c == 12) begin
        have = (type_q == psfp_pkg::TypeHcho) || (type_q == psfp_pkg::TypeHchoTrh);
      end else begin
        have = (type_q == psfp_pkg::TypeTrh) || (type_q == psfp_pkg::TypeHchoTrh);
      end
      if (c < 12) begin
        off = int'(psfp_pkg::OffFirst) + 2 * c;
      end else if (c == 12) begin
        off = int'(psfp_pkg::OffHcho);
      end else begin
        // temperature and humidity move with the frame layout
        off = (type_q == psfp_pkg::TypeTrh) ? int'(psfp_pkg::OffTrhShort)
                                            : int'(psfp_pkg::OffTrhLong);
        off += (c == 14) ? 2 : 0;
      end
      // words that reach into the checksum are not reported (short frames)
      if (have && enable_q[c] && (off + 1 < total_q - 2)) begin
        byte_results.push_back('{kind: KindMeas, channel: 4'(c),
                                 value: {store_bytes[off], store_bytes[off + 1]},
                                 err: NoErr, last: 1'b0});
      end
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    restart_frame();
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int p;
    logic [15:0] len;
    byte_results.delete();
    p = pos_q;
    if (p >= psfp_pkg::MaxFrameBytes) begin
      restart_frame();
      p = 0;
    end
    // a wrong second start byte is dropped, not taken as a new first one
    if ((p == 0 && b != psfp_pkg::StartOne) || (p == 1 && b != psfp_pkg::StartTwo)) begin
      byte_results.push_back(reject_of(psfp_pkg::ErrStart));
      restart_frame();
      return;
    end
    store_bytes[p] = b;
    if (p == 3) begin
      // length is judged with the sensor type in force right now
      len = {store_bytes[2], b};
      if (!length_ok(type_q, len)) begin
        byte_results.push_back(reject_of(psfp_pkg::ErrLength));
        restart_frame();
        return;
      end
      total_q = int'(len) + 4;
    end
    if (p < 4 || p + 2 < total_q) begin
      sum_q  = sum_q + 16'(b);
      pos_q = p + 1;
      return;
    end
    if (p + 1 < total_q) begin
      pos_q = p + 1;
      return;
    end
    if ({store_bytes[p - 1], b} != sum_q) begin
      byte_results.push_back(reject_of(psfp_pkg::ErrChecksum));
      restart_frame();
      return;
    end
    drain_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // receiver side: random stalls, none while no_gaps is set
  always @(negedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IdlePct);
  end

  // one byte transfer; entered and left on a falling edge
  task automatic put_rx_byte(logic [7:0] b, bit typed, parse_result_t want);
    if (!no_gaps && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < IdlePct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // stop sending, let every due result arrive, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(psfp_pkg::cfg_reg_e idx, logic [psfp_pkg::NumChan-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_len();
    if (type_q == psfp_pkg::TypeBasic) begin
      return $urandom_range(0, 1) ? psfp_pkg::LenFull : psfp_pkg::LenShort;
    end
    if (type_q == psfp_pkg::TypeHchoTrh) return psfp_pkg::LenExt;
    return psfp_pkg::LenFull;
  endfunction

  // complete frame with random payload; a flipped checksum bit when bad_sum
  task automatic send_frame(logic [15:0] len, bit bad_sum);
    logic [7:0]  fb[$];
    logic [15:0] s;
    fb.push_back(psfp_pkg::StartOne);
    fb.push_back(psfp_pkg::StartTwo);
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    repeat (int'(len) - 2) fb.push_back(rand_data());
    s = '0;
    foreach (fb[i]) s = s + 16'(fb[i]);
    if (bad_sum) s = s ^ (16'd1 << $urandom_range(0, 15));
    fb.push_back(s[15:8]);
    fb.push_back(s[7:0]);
    foreach (fb[i]) put_rx_byte(fb[i], 1'b0, '0);
  endtask

  // header only, with a length the current type does not allow
  task automatic send_bad_length();
    logic [15:0] len;
    int r;
    do begin
      r = $urandom_range(0, 3);
      case (r)
        0:       len = 16'hFFFF;
        1:       len = 16'h0000;
        2:       len = 16'($urandom_range(0, 48));
        default: len = 16'($urandom_range(0, 65535));
      endcase
    end while (length_ok(type_q, len));
    put_rx_byte(psfp_pkg::StartOne, 1'b0, '0);
    put_rx_byte(psfp_pkg::StartTwo, 1'b0, '0);
    put_rx_byte(len[15:8], 1'b0, '0);
    put_rx_byte(len[7:0], 1'b0, '0);
  endtask

  // line noise, sometimes a first start byte followed by a wrong second one
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      b = 8'($urandom_range(0, 255));
      if (b == psfp_pkg::StartOne) b = b ^ 8'h80;
      put_rx_byte(b, 1'b0, '0);
    end
    if ($urandom_range(0, 1)) begin
      b = 8'($urandom_range(0, 255));
      if (b == psfp_pkg::StartTwo) b = b ^ 8'h01;
      put_rx_byte(psfp_pkg::StartOne, 1'b0, '0);
      put_rx_byte(b, 1'b0, '0);
    end
  endtask

  function automatic void add_byte(logic [7:0] b);
    stim_table.push_back('{op: RowByte, rx: b, idx: psfp_pkg::CfgSensorType, data: '0,
                           typed: 1'b0, want: '0});
  endfunction

  function automatic void add_reject(logic [7:0] b, logic [1:0] code);
    stim_table.push_back('{op: RowByte, rx: b, idx: psfp_pkg::CfgSensorType, data: '0,
                           typed: 1'b1, want: reject_of(code)});
  endfunction

  function automatic void add_cfg(psfp_pkg::cfg_reg_e idx, logic [psfp_pkg::NumChan-1:0] d);
    stim_table.push_back('{op: RowCfg, rx: 8'h00, idx: idx, data: d,
                           typed: 1'b0, want: '0});
  endfunction

  // directed table, starting from the reset configuration
  function automatic void build_table();
    logic [15:0] s;
    logic [7:0]  b;
    // all-zero byte where a start byte belongs
    add_reject(8'h00, psfp_pkg::ErrStart);
    // first start byte good, second wrong: dropped, parser back to idle
    add_byte(psfp_pkg::StartOne);
    add_reject(psfp_pkg::StartOne, psfp_pkg::ErrStart);
    // largest possible announced length
    add_byte(psfp_pkg::StartOne);
    add_byte(psfp_pkg::StartTwo);
    add_byte(8'hFF);
    add_reject(8'hFF, psfp_pkg::ErrLength);
    // short frame: length checked as basic type, sensor type switched
    // mid-frame so the channel set is taken from the extended type
    s = 16'(psfp_pkg::StartOne) + 16'(psfp_pkg::StartTwo) +
        psfp_pkg::LenShort[15:8] + psfp_pkg::LenShort[7:0];
    add_byte(psfp_pkg::StartOne);
    add_byte(psfp_pkg::StartTwo);
    add_byte(psfp_pkg::LenShort[15:8]);
    add_byte(psfp_pkg::LenShort[7:0]);
    for (int i = 0; i < int'(psfp_pkg::LenShort) - 2; i++) begin
      b = (i < 2) ? 8'hFF : (i < 4) ? 8'h00 : 8'(i * 53 + 7);
      s = s + 16'(b);
      add_byte(b);
      if (i == 8) begin
        add_cfg(psfp_pkg::CfgSensorType, psfp_pkg::NumChan'(psfp_pkg::TypeHchoTrh));
      end
    end
    add_byte(s[15:8]);
    add_byte(s[7:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, outputs sampled on the rising edge
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(string what, parse_result_t want,
                                          parse_result_t seen);
    if (mismatches < ShowLimit) begin
      $display("%s at %0t: expected kind %0d ch %0d value %h err %0d last %0d",
               what, $realtime, want.kind, want.channel, want.value, want.err,
               want.last);
      $display("  got kind %0d ch %0d value %h err %0d last %0d",
               seen.kind, seen.channel, seen.value, seen.err, seen.last);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    parse_result_t seen;
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind    = result_kind_e'(m_axis_tuser[0]);
      seen.channel = m_axis_tdata[3:0];
      seen.value   = m_axis_tdata[19:4];
      seen.err     = m_axis_tdata[21:20];
      seen.last    = m_axis_tlast;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing due", '0, seen);
      end else begin
        want = awaited_results.pop_front();
        // the pad bits above the reject reason must stay zero
        if (seen !== want || m_axis_tdata[23:22] !== 2'b00) begin
          report_mismatch("wrong result", want, seen);
        end
      end
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    int base_bytes;
    int r;
    logic [psfp_pkg::NumChan-1:0] en;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = psfp_pkg::CfgSensorType;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    reset_model();
    build_table();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (stim_table[i]) begin
      if (stim_table[i].op == RowCfg) begin
        wait_idle();
        write_reg(stim_table[i].idx, stim_table[i].data);
      end else begin
        put_rx_byte(stim_table[i].rx, stim_table[i].typed, stim_table[i].want);
      end
    end

    // random part: one configuration per phase, mostly good frames
    phase      = 0;
    base_bytes = bytes_sent;
    while (bytes_sent - base_bytes < RandomBytes || phase < MinPhases) begin
      wait_idle();
      case (phase % 5)
        0:       en = '1;
        1:       en = '0;
        3:       en = psfp_pkg::NumChan'(1) << $urandom_range(0, psfp_pkg::NumChan - 1);
        default: en = psfp_pkg::NumChan'($urandom_range(0, 32767));
      endcase
      write_reg(psfp_pkg::CfgSensorType,
                psfp_pkg::NumChan'(phase < 4 ? phase : $urandom_range(0, 3)));
      write_reg(psfp_pkg::CfgChanEnable, en);
      // one long stretch with no idling on either side
      no_gaps = (phase == 2);
      repeat (no_gaps ? 2 : 1) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(pick_len(), 1'b0);
        end else if (r < 80) begin
          send_frame(pick_len(), 1'b1);
        end else if (r < 90) begin
          send_bad_length();
        end else begin
          send_noise();
        end
      end
      no_gaps = 1'b0;
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/psfp_pkg.sv
sv/psfp_ram.sv
sv/psfp_ctrl.sv
sv/psfp_dpath.sv
sv/particulate_sensor_frame_parser.sv
sv/psfp_port_chk.sv
tb/sv/particulate_sensor_frame_parser_tb.sv
